// File: rtl/core/tpta_pkg.sv
package tpta_pkg;

    // sample, state and gain formats
    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int STATE_BITS     = SAMPLE_BITS + 2;
    localparam int GAIN_BITS      = GAIN_FRAC_BITS + 1;

    // datapath widths
    localparam int DIFF_BITS = STATE_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + GAIN_BITS + 1;
    localparam int V_BITS    = DIFF_BITS + 1;
    localparam int WIDE_BITS = V_BITS + 3;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC_BITS;
    localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (GAIN_FRAC_BITS - 1);

    // saturation limits held at the wide width
    localparam logic signed [WIDE_BITS-1:0] STATE_MAX =
        (WIDE_BITS'(1) << (STATE_BITS - 1)) - WIDE_BITS'(1);
    localparam logic signed [WIDE_BITS-1:0] STATE_MIN = ~STATE_MAX;
    localparam logic signed [WIDE_BITS-1:0] SAMPLE_MAX =
        (WIDE_BITS'(1) << (SAMPLE_BITS - 1)) - WIDE_BITS'(1);
    localparam logic signed [WIDE_BITS-1:0] SAMPLE_MIN = ~SAMPLE_MAX;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_USE_FIXED  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIXED_GAIN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MONO       = 2'd2;
    localparam logic [GAIN_BITS-1:0]    FIXED_GAIN_RST = GAIN_BITS'(32768);

    // microprogram
    localparam int UC_PC_BITS = 5;
    localparam logic [UC_PC_BITS-1:0] PC_FIN = 5'd16;

    typedef enum logic [2:0] {
        OP_DIFF   = 3'd0,
        OP_MUL    = 3'd1,
        OP_ROUND  = 3'd2,
        OP_UPDATE = 3'd3,
        OP_FIN    = 3'd4
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic                  chan;      // 0 left, 1 right
        logic                  stage;     // 0 first section, 1 second
        logic                  src_in;    // section input from the request sample
        logic                  save_out;  // section output is the channel result
        logic                  jmp_mono;  // jump to jmp_to when mono
        logic [UC_PC_BITS-1:0] jmp_to;
    } t_ctrl;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic        [GAIN_BITS-1:0]   gain;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } t_out_item;

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [WIDE_BITS-1:0] a);
        logic signed [WIDE_BITS-1:0] c;
        if (a > STATE_MAX) c = STATE_MAX;
        else if (a < STATE_MIN) c = STATE_MIN;
        else c = a;
        return c[STATE_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [WIDE_BITS-1:0] a);
        logic signed [WIDE_BITS-1:0] c;
        if (a > SAMPLE_MAX) c = SAMPLE_MAX;
        else if (a < SAMPLE_MIN) c = SAMPLE_MIN;
        else c = a;
        return c[SAMPLE_BITS-1:0];
    endfunction

endpackage

// File: rtl/core/tpta_ucode_rom.sv
module tpta_ucode_rom
    import tpta_pkg::*;
(
    input  logic [UC_PC_BITS-1:0] i_pc,
    output t_ctrl                 o_ctrl
);

    // one control word per step: four steps for each section of each channel
    always_comb begin
        unique case (i_pc)
            5'd0:    o_ctrl = '{OP_DIFF,   1'b0, 1'b0, 1'b1, 1'b0, 1'b0, PC_FIN};
            5'd1:    o_ctrl = '{OP_MUL,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_FIN};
            5'd2:    o_ctrl = '{OP_ROUND,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_FIN};
            5'd3:    o_ctrl = '{OP_UPDATE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_FIN};
            5'd4:    o_ctrl = '{OP_DIFF,   1'b0, 1'b1, 1'b0, 1'b0, 1'b0, PC_FIN};
            5'd5:    o_ctrl = '{OP_MUL,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0, PC_FIN};
            5'd6:    o_ctrl = '{OP_ROUND,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, PC_FIN};
            5'd7:    o_ctrl = '{OP_UPDATE, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, PC_FIN};
            5'd8:    o_ctrl = '{OP_DIFF,   1'b1, 1'b0, 1'b1, 1'b0, 1'b0, PC_FIN};
            5'd9:    o_ctrl = '{OP_MUL,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PC_FIN};
            5'd10:   o_ctrl = '{OP_ROUND,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PC_FIN};
            5'd11:   o_ctrl = '{OP_UPDATE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PC_FIN};
            5'd12:   o_ctrl = '{OP_DIFF,   1'b1, 1'b1, 1'b0, 1'b0, 1'b0, PC_FIN};
            5'd13:   o_ctrl = '{OP_MUL,    1'b1, 1'b1, 1'b0, 1'b0, 1'b0, PC_FIN};
            5'd14:   o_ctrl = '{OP_ROUND,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, PC_FIN};
            5'd15:   o_ctrl = '{OP_UPDATE, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, PC_FIN};
            default: o_ctrl = '{OP_FIN,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_FIN};
        endcase
    end

endmodule

// File: rtl/core/tpta_datapath.sv
module tpta_datapath
    import tpta_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_in_item             i_item,
    input  logic [GAIN_BITS-1:0] i_gain,
    input  t_ctrl                i_ctrl,
    output t_out_item            o_result
);

    // section states, indexed by {channel, section}
    logic signed [STATE_BITS-1:0]  r_st [4];
    t_in_item                      r_in;
    logic        [GAIN_BITS-1:0]   r_g;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic signed [DIFF_BITS-1:0]   r_d;
    logic signed [PROD_BITS-1:0]   r_p;
    logic signed [V_BITS-1:0]      r_v;
    t_out_item                     r_res;

    logic        [1:0]             st_idx;
    logic signed [STATE_BITS-1:0]  s_cur;
    logic signed [SAMPLE_BITS-1:0] x_src;
    logic signed [PROD_BITS-1:0]   p_round;
    logic signed [WIDE_BITS-1:0]   lp;
    logic signed [WIDE_BITS-1:0]   st_wide;
    logic signed [WIDE_BITS-1:0]   y_wide;
    logic signed [STATE_BITS-1:0]  st_new;
    logic signed [SAMPLE_BITS-1:0] y_new;

    // operand selection, rounding and saturated state and output update
    always_comb begin
        st_idx  = {i_ctrl.chan, i_ctrl.stage};
        s_cur   = r_st[st_idx];
        if (i_ctrl.src_in) begin
            x_src = i_ctrl.chan ? r_in.right_sample : r_in.left_sample;
        end else begin
            x_src = r_y;
        end
        p_round = r_p + ROUND_HALF;
        lp      = WIDE_BITS'(r_v) + WIDE_BITS'(s_cur);
        st_wide = lp + WIDE_BITS'(r_v);
        y_wide  = (lp <<< 1) - WIDE_BITS'(r_x);
        st_new  = sat_state(st_wide);
        y_new   = sat_sample(y_wide);
    end

    // section state, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_st[i] <= '0;
            end
        end else if (i_ctrl.op == OP_UPDATE) begin
            r_st[st_idx] <= st_new;
        end
    end

    // working registers, one operation per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_in            <= i_item;
            r_g             <= i_gain;
            r_res.right_out <= i_item.right_sample;
        end
        unique case (i_ctrl.op)
            OP_DIFF: begin
                r_x <= x_src;
                r_d <= DIFF_BITS'(x_src) - DIFF_BITS'(s_cur);
            end
            OP_MUL: begin
                r_p <= $signed({1'b0, r_g}) * r_d;
            end
            OP_ROUND: begin
                r_v <= p_round[GAIN_FRAC_BITS +: V_BITS];
            end
            OP_UPDATE: begin
                r_y <= y_new;
                if (i_ctrl.save_out) begin
                    if (i_ctrl.chan) begin
                        r_res.right_out <= y_new;
                    end else begin
                        r_res.left_out <= y_new;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result = r_res;

endmodule

// File: rtl/core/two_stage_tpt_allpass_stereo.sv
// channel   direction  handshake                  payload
// in        request    i_in_valid / o_in_ready    i_in_data  (t_in_item)
// out       result     o_out_valid / i_out_ready  o_out_data (t_out_item)
// cfg       write      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// a stereo request runs sixteen microcode steps and a mono one eight, four per section;
// they share one 18x27 multiplier and are followed by one finishing step, then the idle
// state in which the next request is taken
// synchronous active-low reset clears section states, configuration registers and control
// a finished result waits in the output register; the finishing step holds until
// that register is free, so a stalled output only stalls after one more request
module two_stage_tpt_allpass_stereo
    import tpta_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in_item                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_item               o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [GAIN_BITS-1:0]    i_cfg_data
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_seq_state;

    t_seq_state            r_state;
    logic [UC_PC_BITS-1:0] r_pc;
    logic                  r_out_valid;
    t_out_item             r_out;
    logic                  r_use_fixed;
    logic [GAIN_BITS-1:0]  r_fixed_gain;
    logic                  r_mono;

    t_ctrl                 rom_ctrl;
    t_ctrl                 ctrl;
    t_out_item             dp_result;
    logic                  accept;
    logic                  push;
    logic [GAIN_BITS-1:0]  g_sel;
    logic [GAIN_BITS-1:0]  g_clamp;
    logic [UC_PC_BITS-1:0] n_pc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_fixed  <= 1'b0;
            r_fixed_gain <= FIXED_GAIN_RST;
            r_mono       <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_USE_FIXED:  r_use_fixed  <= i_cfg_data[0];
                CFG_FIXED_GAIN: r_fixed_gain <= i_cfg_data;
                CFG_MONO:       r_mono       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // gain selection and clamp to one
    always_comb begin
        g_sel   = r_use_fixed ? r_fixed_gain : i_in_data.gain;
        g_clamp = (g_sel > GAIN_ONE) ? GAIN_ONE : g_sel;
    end

    tpta_ucode_rom u_rom (
        .i_pc   (r_pc),
        .o_ctrl (rom_ctrl)
    );

    // sequencer control
    always_comb begin
        ctrl = rom_ctrl;
        if (r_state != S_RUN) begin
            ctrl.op = OP_FIN;
        end
        accept = i_in_valid && o_in_ready;
        push   = (r_state == S_RUN) && (rom_ctrl.op == OP_FIN)
                 && (!r_out_valid || i_out_ready);
        if (rom_ctrl.jmp_mono && r_mono) begin
            n_pc = rom_ctrl.jmp_to;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    tpta_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_item   (i_in_data),
        .i_gain   (g_clamp),
        .i_ctrl   (ctrl),
        .o_result (dp_result)
    );

    // step counter, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready && !push) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_RUN;
                        r_pc    <= '0;
                    end
                end
                S_RUN: begin
                    if (rom_ctrl.op == OP_FIN) begin
                        if (push) begin
                            r_out_valid <= 1'b1;
                            r_out       <= dp_result;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_pc <= n_pc;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_start_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_RUN) && (r_pc == '0))
        else $error("run did not start at step zero");

    a_pc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_pc <= PC_FIN))
        else $error("step counter beyond microprogram");

    a_mono_jump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RUN) && rom_ctrl.jmp_mono && r_mono) |=> (r_pc == PC_FIN))
        else $error("mono jump not taken");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("pending result dropped");
`endif

endmodule
